/* rtl/core/eed_pkg.sv */
package eed_pkg;

   typedef enum logic [2:0] {
      CMD_TICK      = 3'd0,
      CMD_EXCEPTION = 3'd1,
      CMD_WRITE_MSR = 3'd2,
      CMD_WRITE_DEC = 3'd3,
      CMD_ACK       = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      MMU_NONE       = 3'd0,
      MMU_PAGE_FAULT = 3'd1,
      MMU_PROT_FETCH = 3'd2,
      MMU_NO_EXEC    = 3'd3,
      MMU_PROT_READ  = 3'd4,
      MMU_PROT_WRITE = 3'd5
   } mmu_type;

   typedef enum logic [2:0] {
      PCAUSE_NONE    = 3'd0,
      PCAUSE_FPU     = 3'd1,
      PCAUSE_ILLEGAL = 3'd2,
      PCAUSE_PRIV    = 3'd3,
      PCAUSE_TRAP    = 3'd4
   } pcause_type;

   localparam logic [31:0] VEC_DSI  = 32'h0000_0300;
   localparam logic [31:0] VEC_ISI  = 32'h0000_0400;
   localparam logic [31:0] VEC_PROG = 32'h0000_0700;

   localparam logic [31:0] MSR_EE = 32'h0000_8000;
   localparam logic [31:0] MSR_IR = 32'h0000_0020;
   localparam logic [31:0] MSR_DR = 32'h0000_0010;
   localparam logic [31:0] MSR_RI = 32'h0000_0002;
   localparam logic [31:0] MSR_ENTRY_CLEAR = MSR_EE | MSR_IR | MSR_DR | MSR_RI;

   localparam logic [31:0] DEC_SIGN_BIT = 32'h8000_0000;

   localparam logic [31:0] ISI_KEEP_MASK  = 32'h0fff_ffff;
   localparam logic [31:0] PROG_KEEP_MASK = 32'h0000_ffff;

   localparam logic [31:0] CAUSE_PAGE_FAULT  = 32'h4000_0000;
   localparam logic [31:0] CAUSE_PROT        = 32'h0800_0000;
   localparam logic [31:0] CAUSE_NO_EXEC     = 32'h1000_0000;
   localparam logic [31:0] CAUSE_PROT_STORE  = 32'h0A00_0000;
   localparam logic [31:0] CAUSE_FPU         = 32'h0010_0000;
   localparam logic [31:0] CAUSE_ILLEGAL     = 32'h0008_0000;
   localparam logic [31:0] CAUSE_PRIV        = 32'h0004_0000;
   localparam logic [31:0] CAUSE_TRAP        = 32'h0002_0000;

   localparam logic [15:0] TB_STEP_RESET = 16'd1;

   typedef struct packed {
      logic [31:0] handler_pc;
      logic [31:0] msr;
      logic [31:0] srr0;
      logic [31:0] srr1;
      logic [31:0] dsisr;
      logic [63:0] timebase;
      logic [31:0] decrementer;
      logic        decrementer_request;
      logic        in_exception;
      logic        double_fault;
   } rsp_type;

endpackage

/* rtl/core/exception_entry_and_decrementer.sv */
// Channel  Direction  Handshake            Payload
// req_     in         req_valid/req_stall  command, vector, pc, mmu, cause, value
// rsp_     out        rsp_valid/rsp_stall  handler pc, msr, srr0/1, dsisr, tb, dec, flags
// csr_     in         csr_wr_en            timebase step (16 bit)
//
// One request per cycle while req_stall is low. The architectural registers update
// at the edge that accepts a request, and its response is registered at that edge.
// A skid register behind the output register keeps req_stall registered: the
// block stalls requests during reset and while both hold an unclaimed response.
// Reset (synchronous, active high) clears all but the payload; the step is set to 1.
module exception_entry_and_decrementer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [31:0] req_exception_vector,
   input  logic [31:0] req_current_pc,
   input  logic [2:0]  req_mmu_result,
   input  logic [2:0]  req_program_cause,
   input  logic [31:0] req_write_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_handler_pc,
   output logic [31:0] rsp_msr_out,
   output logic [31:0] rsp_srr0_out,
   output logic [31:0] rsp_srr1_out,
   output logic [31:0] rsp_dsisr_out,
   output logic [63:0] rsp_timebase_out,
   output logic [31:0] rsp_decrementer_out,
   output logic        rsp_decrementer_request,
   output logic        rsp_in_exception,
   output logic        rsp_double_fault,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   // architectural state
   logic [15:0] tb_step_ff;
   logic [31:0] msr_ff,   msr_in;
   logic [31:0] srr0_ff,  srr0_in;
   logic [31:0] srr1_ff,  srr1_in;
   logic [31:0] dsisr_ff, dsisr_in;
   logic [63:0] tb_ff,    tb_in;
   logic [31:0] dec_ff,   dec_in;
   logic        dec_pend_ff, dec_pend_in;
   logic        exc_pend_ff, exc_pend_in;

   // response path: output register and skid register
   eed_pkg::rsp_type out_ff, out_in;
   eed_pkg::rsp_type skid_ff, skid_in;
   logic             out_valid_ff, out_valid_in;
   logic             skid_valid_ff, skid_valid_in;

   eed_pkg::rsp_type step_rsp;
   logic             accept;
   logic             out_taken;
   logic             dbl;
   logic [31:0]      dec_dec;
   logic [31:0]      srr1_exc;
   logic [31:0]      dsisr_exc;

   // hold requests off during reset and while the skid register is occupied
   assign req_stall = skid_valid_ff | reset;
   assign accept    = req_valid & ~req_stall;
   assign out_taken = out_valid_ff & ~rsp_stall;

   // cause bits for the exception entry
   always_comb begin
      srr1_exc  = msr_ff;
      dsisr_exc = dsisr_ff;
      if (req_exception_vector == eed_pkg::VEC_ISI) begin
         srr1_exc = msr_ff & eed_pkg::ISI_KEEP_MASK;
         case (eed_pkg::mmu_type'(req_mmu_result))
            eed_pkg::MMU_PAGE_FAULT: srr1_exc = srr1_exc | eed_pkg::CAUSE_PAGE_FAULT;
            eed_pkg::MMU_PROT_FETCH: srr1_exc = srr1_exc | eed_pkg::CAUSE_PROT;
            eed_pkg::MMU_NO_EXEC:    srr1_exc = srr1_exc | eed_pkg::CAUSE_NO_EXEC;
            default:                 srr1_exc = srr1_exc;
         endcase
      end else if (req_exception_vector == eed_pkg::VEC_DSI) begin
         case (eed_pkg::mmu_type'(req_mmu_result))
            eed_pkg::MMU_PAGE_FAULT: dsisr_exc = eed_pkg::CAUSE_PAGE_FAULT;
            eed_pkg::MMU_PROT_READ:  dsisr_exc = eed_pkg::CAUSE_PROT;
            eed_pkg::MMU_PROT_WRITE: dsisr_exc = eed_pkg::CAUSE_PROT_STORE;
            default:                 dsisr_exc = '0;
         endcase
      end else if (req_exception_vector == eed_pkg::VEC_PROG) begin
         srr1_exc = msr_ff & eed_pkg::PROG_KEEP_MASK;
         case (eed_pkg::pcause_type'(req_program_cause))
            eed_pkg::PCAUSE_FPU:     srr1_exc = srr1_exc | eed_pkg::CAUSE_FPU;
            eed_pkg::PCAUSE_ILLEGAL: srr1_exc = srr1_exc | eed_pkg::CAUSE_ILLEGAL;
            eed_pkg::PCAUSE_PRIV:    srr1_exc = srr1_exc | eed_pkg::CAUSE_PRIV;
            eed_pkg::PCAUSE_TRAP:    srr1_exc = srr1_exc | eed_pkg::CAUSE_TRAP;
            default:                 srr1_exc = srr1_exc;
         endcase
      end
   end

   assign dec_dec = dec_ff - 32'd1;

   // next architectural state for the request on the port
   always_comb begin
      msr_in      = msr_ff;
      srr0_in     = srr0_ff;
      srr1_in     = srr1_ff;
      dsisr_in    = dsisr_ff;
      tb_in       = tb_ff;
      dec_in      = dec_ff;
      dec_pend_in = dec_pend_ff;
      exc_pend_in = exc_pend_ff;
      dbl         = 1'b0;
      unique case (eed_pkg::cmd_type'(req_command))
         eed_pkg::CMD_TICK: begin
            tb_in  = tb_ff + {48'd0, tb_step_ff};
            dec_in = dec_dec;
            // raise the request when the sign bit flips with interrupts on
            if ((((dec_ff ^ dec_dec) & eed_pkg::DEC_SIGN_BIT) != '0) &&
                ((msr_ff & eed_pkg::MSR_EE) != '0)) begin
               dec_pend_in = 1'b1;
            end
         end
         eed_pkg::CMD_EXCEPTION: begin
            dbl         = exc_pend_ff;
            srr0_in     = req_current_pc;
            srr1_in     = srr1_exc;
            dsisr_in    = dsisr_exc;
            msr_in      = msr_ff & ~eed_pkg::MSR_ENTRY_CLEAR;
            exc_pend_in = 1'b1;
         end
         eed_pkg::CMD_WRITE_MSR: begin
            msr_in = req_write_value;
         end
         eed_pkg::CMD_WRITE_DEC: begin
            dec_in = req_write_value;
         end
         eed_pkg::CMD_ACK: begin
            if (req_write_value[0]) begin
               exc_pend_in = 1'b0;
            end
            if (req_write_value[1]) begin
               dec_pend_in = 1'b0;
            end
         end
         default: begin
            // unknown command: leave state alone
            dbl = 1'b0;
         end
      endcase
   end

   // response built from the updated state
   always_comb begin
      step_rsp.handler_pc = (eed_pkg::cmd_type'(req_command) == eed_pkg::CMD_EXCEPTION)
                            ? req_exception_vector : req_current_pc;
      step_rsp.msr                 = msr_in;
      step_rsp.srr0                = srr0_in;
      step_rsp.srr1                = srr1_in;
      step_rsp.dsisr               = dsisr_in;
      step_rsp.timebase            = tb_in;
      step_rsp.decrementer         = dec_in;
      step_rsp.decrementer_request = dec_pend_in;
      step_rsp.in_exception        = exc_pend_in;
      step_rsp.double_fault        = dbl;
   end

   // advance the output register from the skid first, else from the new request;
   // park a new request in the skid when the output register is held
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || out_taken) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = step_rsp;
            out_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = step_rsp;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tb_step_ff    <= eed_pkg::TB_STEP_RESET;
         msr_ff        <= '0;
         srr0_ff       <= '0;
         srr1_ff       <= '0;
         dsisr_ff      <= '0;
         tb_ff         <= '0;
         dec_ff        <= '0;
         dec_pend_ff   <= 1'b0;
         exc_pend_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            tb_step_ff <= csr_wr_data;
         end
         if (accept) begin
            msr_ff      <= msr_in;
            srr0_ff     <= srr0_in;
            srr1_ff     <= srr1_in;
            dsisr_ff    <= dsisr_in;
            tb_ff       <= tb_in;
            dec_ff      <= dec_in;
            dec_pend_ff <= dec_pend_in;
            exc_pend_ff <= exc_pend_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers need no reset
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid               = out_valid_ff;
   assign rsp_handler_pc          = out_ff.handler_pc;
   assign rsp_msr_out             = out_ff.msr;
   assign rsp_srr0_out            = out_ff.srr0;
   assign rsp_srr1_out            = out_ff.srr1;
   assign rsp_dsisr_out           = out_ff.dsisr;
   assign rsp_timebase_out        = out_ff.timebase;
   assign rsp_decrementer_out     = out_ff.decrementer;
   assign rsp_decrementer_request = out_ff.decrementer_request;
   assign rsp_in_exception        = out_ff.in_exception;
   assign rsp_double_fault        = out_ff.double_fault;

   // the skid register is only ever filled behind a full output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a response with the output register empty");

   // the output register holds a valid response after every accepted request
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> out_valid_ff)
      else $error("accepted request produced no response");

   // a double fault is only reported on a step that leaves an exception pending
   a_double_fault_pending: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.double_fault) |-> out_ff.in_exception)
      else $error("double fault reported without a pending exception");

   // an accepted exception leaves the entry bits of the MSR clear
   a_entry_msr_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && eed_pkg::cmd_type'(req_command) == eed_pkg::CMD_EXCEPTION)
      |=> ((msr_ff & eed_pkg::MSR_ENTRY_CLEAR) == '0) && exc_pend_ff)
      else $error("exception entry left MSR entry bits set");

endmodule
